### src/gle_pkg.sv
// package: shared types and constants of the gif lzw stream encoder
`timescale 1ns / 1ps
package gle_pkg;

    localparam int HASH_SIZE_DEF    = 5003;
    localparam int ADDRESS_BITS_DEF = 24;
    localparam int MAX_CODE_BITS    = 12;
    localparam int KEY_W            = 21;
    localparam int DICT_W           = KEY_W + MAX_CODE_BITS;
    localparam int ACC_W            = 19;
    localparam int PORT_ADDR_W      = 24;
    localparam int CFG_DATA_W       = 24;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_CAPACITY = 2'd2;

    localparam logic [7:0] SUB_BLOCK_MAX = 8'd254;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEND,
        ST_DRAIN,
        ST_LEN,
        ST_START,
        ST_CLEAR,
        ST_LASTCHK,
        ST_EOI,
        ST_TAIL1,
        ST_TAIL2,
        ST_TERM,
        ST_FINISH,
        ST_HASH,
        ST_PROBE,
        ST_INSERT,
        ST_FULL
    } gle_state_t;

    typedef struct packed {
        logic                   push;
        logic                   flush;
        logic [7:0]             out_byte;
        logic [PORT_ADDR_W-1:0] byte_address;
        logic                   dropped;
        logic                   image_done;
    } emit_req_t;

    function automatic logic [3:0] clamp_size(input logic [3:0] m);
        logic [3:0] r;
        r = m;
        if (m < 4'd2)
        begin
            r = 4'd2;
        end
        else if (m > 4'd8)
        begin
            r = 4'd8;
        end
        return r;
    endfunction

endpackage

### src/gle_if.sv
// interfaces: pixel stream, byte stream and configuration write channel
`timescale 1ns / 1ps
interface gle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       last;
    modport source (output valid, output pixel, output last, input ready);
    modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface gle_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [23:0] byte_address;
    logic        dropped;
    logic        end_of_run;
    logic        image_done;
    modport source (output valid, output out_byte, output byte_address, output dropped,
                    output end_of_run, output image_done, input ready);
    modport sink   (input valid, input out_byte, input byte_address, input dropped,
                    input end_of_run, input image_done, output ready);
endinterface

interface gle_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/gle_dict_ram.sv
// dictionary memory: one write port, one registered read port
`timescale 1ns / 1ps
module gle_dict_ram #(
    parameter int DEPTH = 5003,
    parameter int WIDTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

### src/gle_emit.sv
// result stage: one held byte for end-of-run marking, then the output register
`timescale 1ns / 1ps
module gle_emit (
    input  logic      clk,
    input  logic      rst_n,
    input  gle_pkg::emit_req_t req,
    output logic      ok,
    gle_byte_if.source out
);
    import gle_pkg::*;

    logic      pend_v_reg, pend_v_next;
    emit_req_t pend_reg, pend_next;
    logic      out_v_reg, out_v_next;
    emit_req_t out_reg, out_next;
    logic      out_eor_reg, out_eor_next;
    logic      out_free;

    assign out_free = !out_v_reg || out.ready;
    assign ok       = !pend_v_reg || out_free;

    always_comb
    begin
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        out_v_next   = out_free ? 1'b0 : out_v_reg;
        out_next     = out_reg;
        out_eor_next = out_eor_reg;
        if (req.push || req.flush)
        begin
            if (pend_v_reg)
            begin
                out_v_next   = 1'b1;
                out_next     = pend_reg;
                out_eor_next = req.flush;
            end
            pend_v_next = req.push;
            if (req.push)
            begin
                pend_next = req;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        out_eor_reg <= out_eor_next;
    end

    assign out.valid        = out_v_reg;
    assign out.out_byte     = out_reg.out_byte;
    assign out.byte_address = out_reg.byte_address;
    assign out.dropped      = out_reg.dropped;
    assign out.image_done   = out_reg.image_done;
    assign out.end_of_run   = out_eor_reg;
endmodule

### src/gif_lzw_stream_encoder.sv
// top level: gif lzw image-data encoder with hashed dictionary in block memory
//
//  channel    dir  transfer fields
//  cfg        in   index, data (code size, start address, capacity)
//  pix_in     in   pixel, last
//  bytes_out  out  out_byte, byte_address, dropped, end_of_run, image_done
//
// a pixel that extends a known string passes hash, probe, last check and finish,
// with one more probe per collision; a new code adds pack, drain check and insert,
// with a drain step per byte out and a length step per length byte
// each dictionary clear (image start, all codes used) sweeps all HASH_SIZE entries,
// one entry a cycle through the dictionary write port; no sweep after reset,
// since every image starts with one before its first lookup
// pix_in.ready is high only in idle; a full output stalls the sequencer
`timescale 1ns / 1ps
module gif_lzw_stream_encoder #(
    parameter int HASH_SIZE    = gle_pkg::HASH_SIZE_DEF,
    parameter int ADDRESS_BITS = gle_pkg::ADDRESS_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gle_cfg_if.sink       cfg,
    gle_pix_if.sink       pix_in,
    gle_byte_if.source    bytes_out
);
    import gle_pkg::*;

    localparam int IW   = $clog2(HASH_SIZE);
    localparam int AW   = ADDRESS_BITS;
    localparam int CMPW = (AW > PORT_ADDR_W) ? AW : PORT_ADDR_W;
    localparam int CW   = MAX_CODE_BITS;

    // configuration registers
    logic [3:0]            mcs_reg;
    logic [CFG_DATA_W-1:0] start_reg;
    logic [CFG_DATA_W-1:0] cap_reg;

    // sequencer state
    gle_state_t state_reg, state_next;
    gle_state_t ret_reg, ret_next;
    logic [7:0]    pix_reg, pix_next;
    logic          last_reg, last_next;
    logic          started_reg, started_next;
    logic [3:0]    size_reg, size_next;
    logic [CW-1:0] prefix_reg, prefix_next;
    logic [CW:0]   nfc_reg, nfc_next;
    logic [3:0]    cw_reg, cw_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [4:0]    bc_reg, bc_next;
    logic [7:0]    fill_reg, fill_next;
    logic [AW-1:0] lsa_reg, lsa_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [CW-1:0] code_reg, code_next;
    logic [IW-1:0] h_reg, h_next;
    logic [IW-1:0] disp_reg, disp_next;
    logic [IW:0]   moves_reg, moves_next;
    logic [IW-1:0] clr_reg, clr_next;

    // dictionary port
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [DICT_W-1:0] ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [DICT_W-1:0] ram_rdata;

    // result stage
    emit_req_t     req;
    logic          emit_ok;
    logic [AW-1:0] emit_addr;

    // derived values
    logic [7:0]       pix_c;
    logic [CW-1:0]    clr_sym;
    logic [KEY_W-1:0] key;
    logic [CW-1:0]    hash0;
    logic [CW-1:0]    cw_mask;
    logic [KEY_W-1:0] rd_key;
    logic [CW-1:0]    rd_code;
    logic [IW:0]      h_step;
    logic [CW+1:0]    nfc_inc;
    logic [3:0]       m_clamped;

    assign pix_c      = pix_reg & 8'((9'd1 << size_reg) - 9'd1);
    assign clr_sym    = CW'(1) << size_reg;
    assign key        = {1'b1, pix_c, prefix_reg};
    assign hash0      = {pix_c, 4'b0000} ^ prefix_reg;
    assign cw_mask    = CW'((13'd1 << cw_reg) - 13'd1);
    assign rd_key     = ram_rdata[DICT_W-1 -: KEY_W];
    assign rd_code    = ram_rdata[CW-1:0];
    assign nfc_inc    = (CW+2)'(nfc_reg) + (CW+2)'(1);
    assign m_clamped  = clamp_size(mcs_reg);
    // backward probe step, wrapping below zero
    assign h_step     = ({1'b0, h_reg} >= {1'b0, disp_reg})
                      ? ({1'b0, h_reg} - {1'b0, disp_reg})
                      : ({1'b0, h_reg} + (IW+1)'(HASH_SIZE) - {1'b0, disp_reg});

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg   <= 4'd8;
            start_reg <= '0;
            cap_reg   <= '1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CODE_SIZE:       mcs_reg   <= cfg.data[3:0];
                CFG_START_ADDRESS:   start_reg <= cfg.data;
                CFG_BUFFER_CAPACITY: cap_reg   <= cfg.data;
                default:             ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_in.valid)
                begin
                    state_next = started_reg ? ST_HASH : ST_INIT;
                end
            end
            ST_INIT:    if (emit_ok) state_next = ST_SEND;
            ST_SEND:    state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (bc_reg < 5'd8)
                begin
                    state_next = ret_reg;
                end
                else if (emit_ok && (fill_reg + 8'd1 == SUB_BLOCK_MAX))
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:     if (emit_ok) state_next = ST_DRAIN;
            ST_START:   state_next = ST_CLEAR;
            ST_CLEAR:   if (clr_reg == IW'(HASH_SIZE - 1)) state_next = ST_LASTCHK;
            ST_LASTCHK: state_next = last_reg ? ST_SEND : ST_FINISH;
            ST_EOI:     state_next = ST_SEND;
            ST_TAIL1:   state_next = (bc_reg != 5'd0) ? ST_DRAIN : ST_TAIL2;
            ST_TAIL2:   if (fill_reg == 8'd0 || emit_ok) state_next = ST_TERM;
            ST_TERM:    if (emit_ok) state_next = ST_FINISH;
            ST_FINISH:  if (emit_ok) state_next = ST_IDLE;
            ST_HASH:    state_next = ST_PROBE;
            ST_PROBE:
            begin
                if (rd_key == key)
                begin
                    state_next = ST_LASTCHK;
                end
                else if (!rd_key[KEY_W-1] || moves_reg == (IW+1)'(HASH_SIZE))
                begin
                    state_next = ST_SEND;
                end
            end
            ST_INSERT:  state_next = nfc_reg[CW] ? ST_SEND : ST_LASTCHK;
            ST_FULL:    state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ret_next     = ret_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        started_next = started_reg;
        size_next    = size_reg;
        prefix_next  = prefix_reg;
        nfc_next     = nfc_reg;
        cw_next      = cw_reg;
        acc_next     = acc_reg;
        bc_next      = bc_reg;
        fill_next    = fill_reg;
        lsa_next     = lsa_reg;
        wa_next      = wa_reg;
        code_next    = code_reg;
        h_next       = h_reg;
        disp_next    = disp_reg;
        moves_next   = moves_reg;
        clr_next     = clr_reg;
        ram_we       = 1'b0;
        ram_waddr    = h_reg;
        ram_wdata    = {key, nfc_reg[CW-1:0]};
        ram_raddr    = h_reg;
        req.push     = 1'b0;
        req.flush    = 1'b0;
        req.out_byte = 8'd0;
        req.image_done = 1'b0;
        emit_addr    = wa_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_in.valid)
                begin
                    pix_next  = pix_in.pixel;
                    last_next = pix_in.last;
                end
            end
            ST_INIT:
            begin
                if (emit_ok)
                begin
                    size_next    = m_clamped;
                    acc_next     = '0;
                    bc_next      = '0;
                    fill_next    = '0;
                    lsa_next     = AW'(start_reg);
                    emit_addr    = AW'(start_reg);
                    wa_next      = AW'(start_reg) + AW'(1);
                    cw_next      = m_clamped + 4'd1;
                    nfc_next     = (CW+1)'((13'd1 << m_clamped) + 13'd2);
                    req.push     = 1'b1;
                    req.out_byte = {4'd0, m_clamped};
                    code_next    = CW'(1) << m_clamped;
                    ret_next     = ST_START;
                end
            end
            ST_SEND:
            begin
                acc_next = acc_reg | (ACC_W'(code_reg & cw_mask) << bc_reg);
                bc_next  = bc_reg + 5'(cw_reg);
            end
            ST_DRAIN:
            begin
                if (bc_reg >= 5'd8 && emit_ok)
                begin
                    // opening a sub-block reserves its length slot first
                    if (fill_reg == 8'd0)
                    begin
                        lsa_next  = wa_reg;
                        emit_addr = wa_reg + AW'(1);
                        wa_next   = wa_reg + AW'(2);
                    end
                    else
                    begin
                        wa_next = wa_reg + AW'(1);
                    end
                    req.push     = 1'b1;
                    req.out_byte = acc_reg[7:0];
                    acc_next     = acc_reg >> 8;
                    bc_next      = bc_reg - 5'd8;
                    fill_next    = fill_reg + 8'd1;
                end
            end
            ST_LEN:
            begin
                emit_addr = lsa_reg;
                if (emit_ok)
                begin
                    req.push     = 1'b1;
                    req.out_byte = SUB_BLOCK_MAX;
                    fill_next    = '0;
                end
            end
            ST_START:
            begin
                prefix_next  = CW'(pix_c);
                started_next = 1'b1;
                clr_next     = '0;
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IW'(1);
            end
            ST_LASTCHK:
            begin
                code_next = prefix_reg;
                ret_next  = ST_EOI;
            end
            ST_EOI:
            begin
                code_next = clr_sym + CW'(1);
                ret_next  = ST_TAIL1;
            end
            ST_TAIL1:
            begin
                // pad the partial byte out to a full one
                if (bc_reg != 5'd0)
                begin
                    bc_next = 5'd8;
                end
                ret_next = ST_TAIL2;
            end
            ST_TAIL2:
            begin
                emit_addr = lsa_reg;
                acc_next  = '0;
                bc_next   = '0;
                if (fill_reg != 8'd0 && emit_ok)
                begin
                    req.push     = 1'b1;
                    req.out_byte = fill_reg;
                    fill_next    = '0;
                end
            end
            ST_TERM:
            begin
                if (emit_ok)
                begin
                    req.push       = 1'b1;
                    req.image_done = 1'b1;
                    wa_next        = wa_reg + AW'(1);
                    started_next   = 1'b0;
                end
            end
            ST_FINISH:
            begin
                req.flush = emit_ok;
            end
            ST_HASH:
            begin
                h_next     = IW'(hash0);
                ram_raddr  = IW'(hash0);
                moves_next = '0;
                disp_next  = (hash0 == '0) ? IW'(1) : IW'(HASH_SIZE) - IW'(hash0);
            end
            ST_PROBE:
            begin
                if (rd_key == key)
                begin
                    prefix_next = rd_code;
                end
                else if (!rd_key[KEY_W-1] || moves_reg == (IW+1)'(HASH_SIZE))
                begin
                    code_next = prefix_reg;
                    ret_next  = ST_INSERT;
                end
                else
                begin
                    h_next     = h_step[IW-1:0];
                    ram_raddr  = h_step[IW-1:0];
                    moves_next = moves_reg + (IW+1)'(1);
                end
            end
            ST_INSERT:
            begin
                prefix_next = CW'(pix_c);
                if (!nfc_reg[CW])
                begin
                    ram_we   = 1'b1;
                    nfc_next = nfc_inc[CW:0];
                    if (nfc_inc >= ((CW+2)'(1) << cw_reg) && cw_reg < 4'(CW))
                    begin
                        cw_next = cw_reg + 4'd1;
                    end
                end
                else
                begin
                    code_next = clr_sym;
                    ret_next  = ST_FULL;
                end
            end
            ST_FULL:
            begin
                nfc_next = (CW+1)'(clr_sym) + (CW+1)'(2);
                cw_next  = size_reg + 4'd1;
                clr_next = '0;
            end
            default: ;
        endcase
        req.byte_address = PORT_ADDR_W'(CMPW'(emit_addr));
        req.dropped      = (CMPW'(emit_addr) >= CMPW'(cap_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            started_reg <= 1'b0;
            size_reg    <= 4'd8;
            prefix_reg  <= '0;
            nfc_reg     <= '0;
            cw_reg      <= '0;
            acc_reg     <= '0;
            bc_reg      <= '0;
            fill_reg    <= '0;
            lsa_reg     <= '0;
            wa_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            started_reg <= started_next;
            size_reg    <= size_next;
            prefix_reg  <= prefix_next;
            nfc_reg     <= nfc_next;
            cw_reg      <= cw_next;
            acc_reg     <= acc_next;
            bc_reg      <= bc_next;
            fill_reg    <= fill_next;
            lsa_reg     <= lsa_next;
            wa_reg      <= wa_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        last_reg  <= last_next;
        code_reg  <= code_next;
        h_reg     <= h_next;
        disp_reg  <= disp_next;
        moves_reg <= moves_next;
        clr_reg   <= clr_next;
    end

    gle_dict_ram #(
        .DEPTH (HASH_SIZE),
        .WIDTH (DICT_W)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gle_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ok    (emit_ok),
        .out   (bytes_out)
    );

`ifndef SYNTH
    // the bit accumulator never holds more than seven bits plus a widest code
    a_bc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= 5'(ACC_W))
        else $error("bit count overflow");

    // a sub-block never reaches full length without its length byte
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LEN) |-> (fill_reg < SUB_BLOCK_MAX))
        else $error("sub-block fill overflow");

    // no dictionary write while a probe reads it
    a_no_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || state_reg == ST_HASH) |-> !ram_we)
        else $error("dictionary write during probe");

    // the terminator byte is always the last result of its pixel
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_out.valid && bytes_out.image_done) |-> bytes_out.end_of_run)
        else $error("terminator without end of run");
`endif
endmodule

### test/testbench.sv
// testbench: gif lzw stream encoder checked transfer by transfer against a built-in encoder
`timescale 1ns / 1ps
module testbench;
    import gle_pkg::*;

    localparam int HSIZE    = HASH_SIZE_DEF;
    localparam int KEY_MARK = 1 << 20;
    localparam int ADDR_MSK = 24'hFFFFFF;
    localparam int LIMIT    = 8000000;
    localparam int SETTLE   = 200;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [23:0] byte_address;
        logic        dropped;
        logic        end_of_run;
        logic        image_done;
    } gif_byte_t;

    // one directed row: either a register write or a pixel
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [23:0] data;
        logic [7:0]  pix;
        bit          last;
        bit          chk;
        logic [7:0]  first_byte;
        logic [23:0] first_addr;
        logic        first_drop;
    } stim_row_t;

    logic clk;
    logic rst_n;

    gle_cfg_if  cfg_bus ();
    gle_pix_if  pix_bus ();
    gle_byte_if byte_bus ();

    gif_lzw_stream_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus.sink),
        .pix_in    (pix_bus.sink),
        .bytes_out (byte_bus.source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // encoder state mirrored by the testbench
    logic [20:0] hash_keys [HSIZE];
    logic [11:0] hash_codes [HSIZE];
    int unsigned cur_prefix, free_code, width_now;
    int unsigned bit_acc, bit_cnt, block_fill;
    int unsigned len_slot, wr_addr, size_used;
    bit          in_image;
    int unsigned reg_size, reg_start, reg_cap;

    gif_byte_t stream_q [$];   // expected transfers of the current pixel
    gif_byte_t pending_q [$];  // expected transfers not yet seen on the output
    int        fails;
    bit        idle_on;
    int        cycles;

    function automatic void put_byte(int unsigned b, int unsigned a, bit done);
        gif_byte_t r;
        if (stream_q.size() >= 16)
        begin
            return;
        end
        a = a & ADDR_MSK;
        r.out_byte     = b[7:0];
        r.byte_address = a[23:0];
        r.dropped      = (a >= reg_cap);
        r.end_of_run   = 1'b0;
        r.image_done   = done;
        stream_q.push_back(r);
    endfunction

    // data byte with the length slot opened ahead and filled when the sub-block is full
    function automatic void put_data(int unsigned b);
        if (block_fill == 0)
        begin
            len_slot = wr_addr;
            wr_addr  = (wr_addr + 1) & ADDR_MSK;
        end
        put_byte(b, wr_addr, 1'b0);
        wr_addr = (wr_addr + 1) & ADDR_MSK;
        block_fill++;
        if (block_fill >= SUB_BLOCK_MAX)
        begin
            put_byte(SUB_BLOCK_MAX, len_slot, 1'b0);
            block_fill = 0;
        end
    endfunction

    function automatic void pack_code(int unsigned code);
        code    = code & ((1 << width_now) - 1);
        bit_acc = bit_acc | (code << bit_cnt);
        bit_cnt = bit_cnt + width_now;
        while (bit_cnt >= 8)
        begin
            put_data(bit_acc & 8'hFF);
            bit_acc = bit_acc >> 8;
            bit_cnt = bit_cnt - 8;
        end
    endfunction

    function automatic void wipe_dict();
        for (int i = 0; i < HSIZE; i++)
        begin
            hash_keys[i] = '0;
        end
    endfunction

    // double hashed lookup, insert on a miss, clear when all codes are used
    function automatic void lzw_extend(int unsigned c);
        int unsigned key, h, disp, clr;
        bit          hit;
        key = KEY_MARK | ((c << MAX_CODE_BITS) + cur_prefix);
        h   = ((c << (MAX_CODE_BITS - 8)) ^ cur_prefix) % HSIZE;
        clr = 1 << size_used;
        hit = 1'b0;
        if (hash_keys[h] == key)
        begin
            hit = 1'b1;
        end
        else if (hash_keys[h][20])
        begin
            disp = (h == 0) ? 1 : HSIZE - h;
            for (int n = 0; n < HSIZE; n++)
            begin
                h = (h >= disp) ? h - disp : h + HSIZE - disp;
                if (hash_keys[h] == key)
                begin
                    hit = 1'b1;
                    break;
                end
                if (!hash_keys[h][20])
                begin
                    break;
                end
            end
        end
        if (hit)
        begin
            cur_prefix = hash_codes[h];
            return;
        end
        pack_code(cur_prefix);
        cur_prefix = c;
        if (free_code < (1 << MAX_CODE_BITS))
        begin
            hash_codes[h] = free_code[11:0];
            hash_keys[h]  = key[20:0];
            free_code++;
            if (free_code >= (1 << width_now) && width_now < MAX_CODE_BITS)
            begin
                width_now++;
            end
        end
        else
        begin
            pack_code(clr);
            wipe_dict();
            free_code = clr + 2;
            width_now = size_used + 1;
        end
    endfunction

    // expected transfers for one accepted pixel, appended to pending_q
    function automatic void predict_pixel(logic [7:0] pix, bit last);
        int unsigned m;
        stream_q.delete();
        if (!in_image)
        begin
            m = reg_size;
            if (m < 2)
            begin
                m = 2;
            end
            if (m > 8)
            begin
                m = 8;
            end
            size_used  = m;
            wipe_dict();
            bit_acc    = 0;
            bit_cnt    = 0;
            block_fill = 0;
            wr_addr    = reg_start & ADDR_MSK;
            len_slot   = wr_addr;
            width_now  = m + 1;
            free_code  = (1 << m) + 2;
            put_byte(m, wr_addr, 1'b0);
            wr_addr    = (wr_addr + 1) & ADDR_MSK;
            pack_code(1 << m);
            cur_prefix = pix & ((1 << m) - 1);
            in_image   = 1'b1;
        end
        else
        begin
            lzw_extend(pix & ((1 << size_used) - 1));
        end
        if (last)
        begin
            pack_code(cur_prefix);
            pack_code((1 << size_used) + 1);
            if (bit_cnt > 0)
            begin
                put_data(bit_acc & 8'hFF);
            end
            bit_acc = 0;
            bit_cnt = 0;
            if (block_fill > 0)
            begin
                put_byte(block_fill, len_slot, 1'b0);
            end
            block_fill = 0;
            put_byte(0, wr_addr, 1'b1);
            wr_addr  = (wr_addr + 1) & ADDR_MSK;
            in_image = 1'b0;
        end
        if (stream_q.size() > 0)
        begin
            stream_q[stream_q.size() - 1].end_of_run = 1'b1;
        end
        foreach (stream_q[i])
        begin
            pending_q.push_back(stream_q[i]);
        end
    endfunction

    // register write, applied to the mirror on the transfer
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_CODE_SIZE:       reg_size  = val[3:0];
            CFG_START_ADDRESS:   reg_start = val;
            CFG_BUFFER_CAPACITY: reg_cap   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // one pixel transfer, optionally preceded by an idle burst
    task automatic push_pixel(logic [7:0] pix, bit last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pix_bus.valid = 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            @(negedge clk);
        end
        pix_bus.valid = 1'b1;
        pix_bus.pixel = pix;
        pix_bus.last  = last;
        @(posedge clk);
        while (!pix_bus.ready)
        begin
            @(posedge clk);
        end
        predict_pixel(pix, last);
    endtask

    // drop valid, let every expected transfer arrive, then let the block settle
    task automatic drain();
        @(negedge clk);
        pix_bus.valid = 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // output side: random bursts of ready low while idling is on
    initial
    begin
        int stall_left;
        stall_left     = 0;
        byte_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                byte_bus.ready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                byte_bus.ready = 1'b0;
                stall_left     = $urandom_range(1, 4) - 1;
            end
            else
            begin
                byte_bus.ready = 1'b1;
            end
        end
    end

    // compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        gif_byte_t want;
        if (rst_n && byte_bus.valid && byte_bus.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none actual byte %h addr %h",
                         $time, byte_bus.out_byte, byte_bus.byte_address);
                fails++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (byte_bus.out_byte !== want.out_byte)
                begin
                    $display("%0t out_byte: expected %h actual %h",
                             $time, want.out_byte, byte_bus.out_byte);
                    fails++;
                end
                if (byte_bus.byte_address !== want.byte_address)
                begin
                    $display("%0t byte_address: expected %h actual %h",
                             $time, want.byte_address, byte_bus.byte_address);
                    fails++;
                end
                if (byte_bus.dropped !== want.dropped)
                begin
                    $display("%0t dropped: expected %b actual %b",
                             $time, want.dropped, byte_bus.dropped);
                    fails++;
                end
                if (byte_bus.end_of_run !== want.end_of_run)
                begin
                    $display("%0t end_of_run: expected %b actual %b",
                             $time, want.end_of_run, byte_bus.end_of_run);
                    fails++;
                end
                if (byte_bus.image_done !== want.image_done)
                begin
                    $display("%0t image_done: expected %b actual %b",
                             $time, want.image_done, byte_bus.image_done);
                    fails++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("gif_lzw_stream_encoder regression: fail");
            $finish;
        end
    end

    stim_row_t rows [25];

    initial
    begin
        int          len, budget;
        int unsigned m, lim;
        logic [7:0]  p;
        logic [23:0] sa, cap;

        // mirror at reset
        wipe_dict();
        for (int i = 0; i < HSIZE; i++)
        begin
            hash_codes[i] = '0;
        end
        cur_prefix = 0; free_code = 0; width_now = 0;
        bit_acc = 0; bit_cnt = 0; block_fill = 0;
        len_slot = 0; wr_addr = 0; in_image = 1'b0; size_used = 8;
        reg_size = 8; reg_start = 0; reg_cap = 24'hFFFFFF;
        fails   = 0;
        cycles  = 0;
        idle_on = 1'b1;

        rst_n         = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_CODE_SIZE;
        cfg_bus.data  = '0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        pix_bus.last  = 1'b0;

        // directed table: reset values, clamping, wrap, full drop, known strings
        rows = '{
            '{0, CFG_CODE_SIZE,       24'h0,      8'h00, 0, 1, 8'd8, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'hFF, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'hFF, 1, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_CODE_SIZE,       24'h0,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_START_ADDRESS,   24'hFFFFFE, 8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_BUFFER_CAPACITY, 24'h3,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            // single pixel image, oversized pixel, address wraps past the top
            '{0, CFG_CODE_SIZE,       24'h0,      8'hFF, 1, 1, 8'd2, 24'hFFFFFE, 1'b1},
            '{1, CFG_CODE_SIZE,       24'hF,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_START_ADDRESS,   24'd100,    8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_BUFFER_CAPACITY, 24'h0,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h80, 0, 1, 8'd8, 24'd100,    1'b1},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h80, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h80, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h80, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h80, 1, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_CODE_SIZE,       24'h4,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_START_ADDRESS,   24'h0,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{1, CFG_BUFFER_CAPACITY, 24'hFFFFFF, 8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h00, 0, 1, 8'd4, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h01, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h00, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h01, 0, 0, 8'd0, 24'h0,      1'b0},
            '{0, CFG_CODE_SIZE,       24'h0,      8'h0F, 1, 0, 8'd0, 24'h0,      1'b0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                // registers only change with the block idle
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
            begin
                push_pixel(rows[i].pix, rows[i].last);
                if (rows[i].chk && (stream_q.size() == 0 ||
                    stream_q[0].out_byte !== rows[i].first_byte ||
                    stream_q[0].byte_address !== rows[i].first_addr ||
                    stream_q[0].dropped !== rows[i].first_drop))
                begin
                    $display("%0t row %0d first transfer: expected %h@%h/%b actual %p",
                             $time, i, rows[i].first_byte, rows[i].first_addr,
                             rows[i].first_drop, stream_q);
                    fails++;
                end
            end
        end

        // random phases: new settings, then a run of short images
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:       m = 0;
                1:       m = 2;
                2:       m = 8;
                3:       m = 15;
                default: m = $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 3))
                0:       sa = 24'h0;
                1:       sa = 24'(24'hFFFFFF - $urandom_range(0, 20));
                default: sa = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            case ($urandom_range(0, 3))
                0:       cap = 24'h0;
                1:       cap = 24'hFFFFFF;
                2:       cap = 24'(sa + $urandom_range(0, 40));
                default: cap = 24'($urandom_range(0, 24'hFFFFFF));
            endcase
            write_reg(CFG_CODE_SIZE, m[23:0]);
            write_reg(CFG_START_ADDRESS, sa);
            write_reg(CFG_BUFFER_CAPACITY, cap);
            budget = 28;
            while (budget > 0)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
                // small alphabets repeat strings so the dictionary gets hits
                lim = ($urandom_range(0, 1) == 0) ? 3 : (1 << size_used) - 1;
                for (int k = 0; k < len; k++)
                begin
                    p = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, lim));
                    push_pixel(p, k == len - 1);
                end
                budget -= len;
            end
        end

        // last stretch without idling on either side
        drain();
        idle_on = 1'b0;
        write_reg(CFG_CODE_SIZE, 24'd8);
        write_reg(CFG_START_ADDRESS, 24'h10);
        write_reg(CFG_BUFFER_CAPACITY, 24'hFFFFFF);
        for (int k = 0; k < 24; k++)
        begin
            push_pixel(8'($urandom_range(0, 3)), k == 23);
        end
        drain();

        if (fails == 0)
        begin
            $display("gif_lzw_stream_encoder regression: pass");
        end
        else
        begin
            $display("gif_lzw_stream_encoder regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
src/gle_pkg.sv
src/gle_if.sv
src/gle_dict_ram.sv
src/gle_emit.sv
src/gif_lzw_stream_encoder.sv
test/testbench.sv
